// ----- design/iptlp_pkg.sv -----
package iptlp_pkg;

    // Character codes the parser reacts to
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_DOT     = 8'd46;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_NINE    = 8'd57;
    localparam logic [7:0] CH_PAUSE   = 8'd80;

    // Octet value that marks "passed 255"
    localparam logic [8:0] OCTET_OVER = 9'd256;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_line;
    } in_item_t;

    typedef struct packed {
        logic        is_pause;
        logic [31:0] ip_addr;
        logic [31:0] timeout;
        logic        status;
    } out_item_t;

endpackage

// ----- design/iptlp_parse.sv -----
module iptlp_parse
    import iptlp_pkg::*;
#(
    parameter int TIMEOUT_BITS = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_item_t  item,
    output logic      line_end,
    output out_item_t result
);

    typedef enum logic [4:0] {
        PH_LEAD = 5'b00001,
        PH_ADDR = 5'b00010,
        PH_GAP  = 5'b00100,
        PH_TMO  = 5'b01000,
        PH_DONE = 5'b10000
    } phase_t;

    localparam int TW = TIMEOUT_BITS + 4;

    phase_t                    phase_reg, phase_next;
    logic [1:0]                count_reg, count_next;
    logic [8:0]                octet_reg, octet_next;
    logic [31:0]               addr_reg, addr_next;
    logic [TIMEOUT_BITS-1:0]   tmo_reg, tmo_next;
    logic                      pause_reg, pause_next;
    logic                      err_reg, err_next;

    logic                      is_digit;
    logic [3:0]                digit;
    logic [11:0]               octet_prod;
    logic [TW-1:0]             tmo_prod;
    logic [TIMEOUT_BITS-1:0]   tmo_step;
    logic                      is_sep;
    logic                      line_err;

    assign is_digit = (item.text_byte >= CH_ZERO) && (item.text_byte <= CH_NINE);
    assign digit    = 4'(item.text_byte - CH_ZERO);
    assign line_end = item.end_of_line || (item.text_byte == CH_NEWLINE);

    // octet * 10 + digit; capped at 256 where it is stored
    assign octet_prod = 12'({octet_reg, 3'b000}) + 12'({octet_reg, 1'b0}) + 12'(digit);

    // timeout * 10 + digit, saturating
    assign tmo_prod = (TW'(tmo_reg) << 3) + (TW'(tmo_reg) << 1) + TW'(digit);
    assign tmo_step = (tmo_prod[TW-1:TIMEOUT_BITS] != '0) ? '1 : tmo_prod[TIMEOUT_BITS-1:0];

    assign is_sep = ((count_reg != 2'd3) && (item.text_byte == CH_DOT)) ||
                    ((count_reg == 2'd3) && (item.text_byte == CH_SPACE));

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        octet_next = octet_reg;
        addr_next  = addr_reg;
        tmo_next   = tmo_reg;
        pause_next = pause_reg;
        err_next   = err_reg;

        unique case (phase_reg)
            PH_LEAD, PH_ADDR:
            begin
                if (phase_reg == PH_LEAD && item.text_byte == CH_SPACE)
                begin
                    phase_next = PH_LEAD;
                end
                else if (phase_reg == PH_LEAD && item.text_byte == CH_PAUSE)
                begin
                    pause_next = 1'b1;
                    phase_next = PH_GAP;
                end
                else if (is_digit)
                begin
                    phase_next = PH_ADDR;
                    octet_next = (octet_prod > 12'(OCTET_OVER)) ? OCTET_OVER : octet_prod[8:0];
                end
                else if (is_sep && !octet_reg[8])
                begin
                    addr_next  = {addr_reg[23:0], octet_reg[7:0]};
                    octet_next = '0;
                    if (count_reg == 2'd3)
                    begin
                        phase_next = PH_GAP;
                    end
                    else
                    begin
                        phase_next = PH_ADDR;
                        count_next = count_reg + 2'd1;
                    end
                end
                else
                begin
                    // bad character, or separator after an octet above 255
                    err_next   = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            PH_GAP:
            begin
                if (is_digit)
                begin
                    phase_next = PH_TMO;
                    tmo_next   = tmo_step;
                end
                else if (item.text_byte != CH_SPACE)
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_TMO:
            begin
                if (is_digit)
                begin
                    tmo_next = tmo_step;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    assign line_err = err_next || (phase_next == PH_LEAD) || (phase_next == PH_ADDR);

    always_comb
    begin
        if (line_err)
        begin
            result.is_pause = 1'b0;
            result.ip_addr  = '0;
            result.timeout  = '0;
            result.status   = STATUS_ERR;
        end
        else
        begin
            result.is_pause = pause_next;
            result.ip_addr  = pause_next ? 32'd0 : addr_next;
            result.timeout  = 32'(tmo_next);
            result.status   = STATUS_OK;
        end
    end

    // Advance on each processed byte; clear the line state at its end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            count_reg <= '0;
            octet_reg <= '0;
            addr_reg  <= '0;
            tmo_reg   <= '0;
            pause_reg <= 1'b0;
            err_reg   <= 1'b0;
        end
        else if (step)
        begin
            if (line_end)
            begin
                phase_reg <= PH_LEAD;
                count_reg <= '0;
                octet_reg <= '0;
                addr_reg  <= '0;
                tmo_reg   <= '0;
                pause_reg <= 1'b0;
                err_reg   <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                octet_reg <= octet_next;
                addr_reg  <= addr_next;
                tmo_reg   <= tmo_next;
                pause_reg <= pause_next;
                err_reg   <= err_next;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_ADDR && phase_reg != PH_LEAD) |-> (octet_reg == '0 || phase_reg == PH_DONE))
        else $error("octet accumulator left nonzero after the address");

    assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> (phase_reg == PH_DONE))
        else $error("error flag set outside the done phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LEAD) |-> (count_reg == '0 && addr_reg == '0 && !pause_reg))
        else $error("line state not clear during leading skip");

endmodule

// ----- design/ip_timeout_line_parser.sv -----
// Line parser for "<address> <timeout>" text lines, one ASCII byte per input
// transaction. A line ends at a newline or at a byte flagged end_of_line, and
// that byte yields exactly one output transaction; all other bytes yield none.
// After leading spaces a line holds either 'P' (pause, address 0) or a dotted
// quad of four decimal octets (empty octets and leading zeros allowed, each at
// most 255) closed by one space, then optional spaces and a decimal timeout
// that stops at the first non-digit and saturates at 2^TIMEOUT_BITS-1. A bad
// or unfinished address gives address 0, timeout 0 and status 1. The block
// takes one byte every cycle unless stalled: each byte is a single state
// update in the parser between the input register and the output register.
// A waiting result stalls the input side only when the byte being processed
// ends another line.
module ip_timeout_line_parser
    import iptlp_pkg::*;
#(
    parameter int TIMEOUT_BITS = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic      in_valid_reg, in_valid_next;
    in_item_t  in_data_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg;

    logic      step;
    logic      line_end;
    out_item_t line_result;

    iptlp_parse #(
        .TIMEOUT_BITS (TIMEOUT_BITS)
    ) u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .item     (in_data_reg),
        .line_end (line_end),
        .result   (line_result)
    );

    // Process the held byte unless it ends a line while a result still waits
    assign step = in_valid_reg && (!line_end || !out_valid_reg || out_ready);

    // Take a new byte whenever the input register is empty or drains this cycle
    assign in_ready = !in_valid_reg || step;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ready)
        begin
            in_valid_next = in_valid;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step && line_end)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on transaction, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
        if (step && line_end)
        begin
            out_data_reg <= line_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        !(step && line_end && out_valid_reg && !out_ready))
        else $error("result overwritten before it was taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !step) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("stalled byte lost or changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.status == STATUS_ERR) |->
            (out_data_reg.ip_addr == '0 && out_data_reg.timeout == '0 && !out_data_reg.is_pause))
        else $error("error result carries data");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_data_reg.timeout >> TIMEOUT_BITS) == '0))
        else $error("timeout wider than its configured width");

endmodule

// ----- sim/tb_ip_timeout_line_parser.sv -----
module tb_ip_timeout_line_parser
    import iptlp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Timeout width of the instance and the value it saturates at
    localparam int          TMO_BITS       = 32;
    localparam logic [63:0] TMO_MAX        = (64'd1 << TMO_BITS) - 64'd1;
    // Cycles without any transaction before the run is declared hung
    localparam int          WATCHDOG_LIMIT = 1500;
    // Receiver hold-off that backs the parser up into its input side
    localparam int          LONG_STALL     = 400;
    localparam int          STALL_AFTER    = 300;
    // Settling wait after all results are back
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          CHUNK_BYTES    = 500;
    localparam int          IDLE_PERCENT   = 20;

    // Parse position within the current line
    typedef enum logic [4:0] {
        SKIP_LEAD  = 5'b00001,
        IN_ADDR    = 5'b00010,
        SKIP_GAP   = 5'b00100,
        IN_TIMEOUT = 5'b01000,
        LINE_DONE  = 5'b10000
    } line_phase_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    ip_timeout_line_parser #(
        .TIMEOUT_BITS (TMO_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Bytes waiting for the driver, and the line being assembled
    in_item_t    pending_bytes[$];
    logic [7:0]  line_buf[$];
    // Line results predicted but not yet seen at the output
    out_item_t   expected_lines[$];

    // Predicted parser state
    line_phase_t line_phase;
    logic [1:0]  octets_done;
    logic [8:0]  octet_acc;
    logic [31:0] addr_acc;
    logic [31:0] tmo_acc;
    logic        pause_seen;
    logic        addr_bad;

    int  error_count  = 0;
    int  bytes_taken  = 0;
    int  bytes_queued = 0;
    int  idle_count   = 0;
    int  stall_left   = 0;
    bit  stall_done   = 1'b0;
    bit  no_idle      = 1'b0;
    bit  in_taken     = 1'b0;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Line predictor
    // ------------------------------------------------------------------
    function automatic bit is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    task automatic clear_line_state();
        line_phase  = SKIP_LEAD;
        octets_done = '0;
        octet_acc   = '0;
        addr_acc    = '0;
        tmo_acc     = '0;
        pause_seen  = 1'b0;
        addr_bad    = 1'b0;
    endtask

    // Accumulate one timeout digit, clamping at the maximum
    task automatic add_timeout_digit(input logic [7:0] c);
        logic [63:0] nv;
        nv = {32'd0, tmo_acc} * 64'd10 + {56'd0, c - CH_ZERO};
        if (nv > TMO_MAX)
            nv = TMO_MAX;
        tmo_acc = nv[31:0];
    endtask

    // Advance the dotted-quad scan by one character
    task automatic add_address_char(input logic [7:0] c);
        int nv;
        if (is_digit(c))
        begin
            nv = int'(octet_acc) * 10 + int'(c - CH_ZERO);
            octet_acc = (nv > int'(OCTET_OVER)) ? OCTET_OVER : nv[8:0];
        end
        else if ((octets_done < 2'd3 && c == CH_DOT) ||
                 (octets_done == 2'd3 && c == CH_SPACE))
        begin
            if (octet_acc >= OCTET_OVER)
            begin
                addr_bad   = 1'b1;
                line_phase = LINE_DONE;
            end
            else
            begin
                addr_acc  = {addr_acc[23:0], octet_acc[7:0]};
                octet_acc = '0;
                if (octets_done == 2'd3)
                    line_phase = SKIP_GAP;
                else
                    octets_done = octets_done + 2'd1;
            end
        end
        else
        begin
            addr_bad   = 1'b1;
            line_phase = LINE_DONE;
        end
    endtask

    // Consume one accepted byte; queue a result when it closes the line
    task automatic parse_byte(input in_item_t item);
        logic [7:0] c;
        out_item_t  res;
        c = item.text_byte;
        case (line_phase)
            SKIP_LEAD:
            begin
                if (c == CH_SPACE)
                    ;
                else if (c == CH_PAUSE)
                begin
                    pause_seen = 1'b1;
                    line_phase = SKIP_GAP;
                end
                else
                begin
                    line_phase = IN_ADDR;
                    add_address_char(c);
                end
            end
            IN_ADDR:
                add_address_char(c);
            SKIP_GAP:
            begin
                if (c == CH_SPACE)
                    ;
                else if (is_digit(c))
                begin
                    line_phase = IN_TIMEOUT;
                    add_timeout_digit(c);
                end
                else
                    line_phase = LINE_DONE;
            end
            IN_TIMEOUT:
            begin
                if (is_digit(c))
                    add_timeout_digit(c);
                else
                    line_phase = LINE_DONE;
            end
            default:
                ;
        endcase

        if (item.end_of_line || c == CH_NEWLINE)
        begin
            // An address that never completed counts as malformed
            if (addr_bad || line_phase == SKIP_LEAD || line_phase == IN_ADDR)
            begin
                res.is_pause = 1'b0;
                res.ip_addr  = '0;
                res.timeout  = '0;
                res.status   = STATUS_ERR;
            end
            else
            begin
                res.is_pause = pause_seen;
                res.ip_addr  = pause_seen ? 32'd0 : addr_acc;
                res.timeout  = tmo_acc;
                res.status   = STATUS_OK;
            end
            expected_lines.push_back(res);
            clear_line_state();
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge, check results,
    // feed accepted bytes to the predictor and run the watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        out_item_t want;
        bit        moved;
        moved    = 1'b0;
        in_taken = 1'b0;
        if (rst_n)
        begin
            // Check the result before the byte of this edge is parsed;
            // a byte cannot produce its own result in the same cycle
            if (out_valid && out_ready)
            begin
                moved = 1'b1;
                if (expected_lines.size() == 0)
                begin
                    $error("unexpected result transaction: addr %0d timeout %0d",
                           out_data.ip_addr, out_data.timeout);
                    error_count++;
                end
                else
                begin
                    want = expected_lines.pop_front();
                    compare_field("is_pause", want.is_pause, out_data.is_pause);
                    compare_field("ip_addr", want.ip_addr, out_data.ip_addr);
                    compare_field("timeout", want.timeout, out_data.timeout);
                    compare_field("status", want.status, out_data.status);
                end
            end
            if (in_valid && in_ready)
            begin
                moved    = 1'b1;
                in_taken = 1'b1;
                bytes_taken++;
                parse_byte(in_data);
            end
        end

        // Count cycles with no transaction on either side
        if (moved)
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: present the next pending byte at the falling edge; hold
    // valid and payload until the transaction is taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pending_bytes.size() > 0 &&
                (no_idle || $urandom_range(99) >= IDLE_PERCENT))
            begin
                in_data  <= pending_bytes.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, plus one long hold-off once enough
    // bytes have gone in, so the parser fills and stalls its input
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!stall_done && bytes_taken >= STALL_AFTER)
            begin
                stall_done = 1'b1;
                stall_left = LONG_STALL;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    // Append a string as one line; optionally flag the last character end of line
    task automatic push_text(input string s, input bit eol_last);
        in_item_t item;
        for (int i = 0; i < s.len(); i++)
        begin
            item.text_byte   = s[i];
            item.end_of_line = eol_last && (i == s.len() - 1);
            pending_bytes.push_back(item);
        end
    endtask

    task automatic push_decimal(input longint unsigned v, input int zeros);
        string s;
        s = $sformatf("%0d", v);
        repeat (zeros) line_buf.push_back(CH_ZERO);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    // Move the assembled line into the pending queue. Close it either with
    // a newline or by flagging its last byte; noisy lines also get random
    // end-of-line flags in the middle.
    task automatic emit_line(input bit noisy);
        in_item_t item;
        bit       eol_end;
        eol_end = 1'($urandom_range(1));
        if (line_buf.size() == 0)
            eol_end = 1'b0;
        foreach (line_buf[i])
        begin
            item.text_byte   = line_buf[i];
            item.end_of_line = noisy && ($urandom_range(9) == 0);
            if (eol_end && i == line_buf.size() - 1)
                item.end_of_line = 1'b1;
            pending_bytes.push_back(item);
        end
        if (!eol_end)
        begin
            item.text_byte   = CH_NEWLINE;
            item.end_of_line = 1'($urandom_range(1));
            pending_bytes.push_back(item);
        end
        bytes_queued += line_buf.size() + (eol_end ? 0 : 1);
        line_buf.delete();
    endtask

    // Mostly well-formed lines with random content; the rest raw noise
    // or well-formed lines with one byte corrupted
    task automatic make_random_line();
        int kind;
        int sel;
        kind = $urandom_range(99);
        if (kind < 20)
        begin
            repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom_range(255)));
            emit_line(1'b1);
        end
        else
        begin
            repeat ($urandom_range(3)) line_buf.push_back(CH_SPACE);
            if (kind < 35)
                line_buf.push_back(CH_PAUSE);
            else
            begin
                for (int k = 0; k < 4; k++)
                begin
                    sel = $urandom_range(19);
                    if (sel == 0)
                        ;                                   // empty octet
                    else if (sel == 1)
                        push_decimal(64'($urandom_range(256, 999)), 0);
                    else if (sel == 2)
                        push_decimal(64'd255, 0);
                    else if (sel == 3)
                        push_decimal(64'd0, 0);
                    else
                        push_decimal(64'($urandom_range(255)),
                                     ($urandom_range(4) == 0) ?
                                         int'($urandom_range(1, 3)) : 0);
                    line_buf.push_back((k < 3) ? CH_DOT : CH_SPACE);
                end
            end
            repeat ($urandom_range(3)) line_buf.push_back(CH_SPACE);

            // Timeout: none, long (mostly saturating), the boundary, or short
            sel = $urandom_range(9);
            if (sel == 1)
                repeat ($urandom_range(10, 12))
                    line_buf.push_back(8'(CH_ZERO + $urandom_range(9)));
            else if (sel == 2)
                push_decimal(64'd4294967295 + 64'($urandom_range(1)), 0);
            else if (sel != 0)
                repeat ($urandom_range(1, 5))
                    line_buf.push_back(8'(CH_ZERO + $urandom_range(9)));

            // Trailing text after the timeout is ignored
            if ($urandom_range(3) == 0)
            begin
                line_buf.push_back(8'($urandom_range(58, 126)));
                repeat ($urandom_range(3)) line_buf.push_back(8'($urandom_range(33, 126)));
            end

            if (kind < 45)
                line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
            emit_line(1'b0);
        end
    endtask

    // Stop feeding until everything sent has come back, then let the
    // pipeline settle
    task automatic wait_for_drain();
        while (pending_bytes.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_lines.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        in_item_t item;
        int       target;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        clear_line_state();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed lines: blank, all spaces, pause with trailing text,
        // empty octets, octet above 255, bad first byte, unfinished address
        push_text("\n", 1'b0);
        push_text(" ", 1'b1);
        push_text("P9x\n", 1'b0);
        push_text("... 7", 1'b1);
        push_text("256.", 1'b1);
        item.text_byte   = 8'hFF;
        item.end_of_line = 1'b1;
        pending_bytes.push_back(item);
        push_text("1.2 ", 1'b1);
        item.text_byte   = CH_NEWLINE;
        item.end_of_line = 1'b1;
        pending_bytes.push_back(item);
        wait_for_drain();

        // Random chunks; pause after each until all results are back, and
        // run one chunk with no idling on either side
        for (int chunk = 0; chunk < 4; chunk++)
        begin
            no_idle = (chunk == 2);
            target  = bytes_queued + CHUNK_BYTES;
            while (bytes_queued < target)
                make_random_line();
            wait_for_drain();
        end
        no_idle = 1'b0;

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
